>>> rtl/binary_erosion_3x3_top_macros.svh
// Assertion macros for the binary erosion block checker.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef BINARY_EROSION_3X3_TOP_MACROS_SVH
`define BINARY_EROSION_3X3_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BERO_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define BERO_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bero_pkg.sv
// Shared constants, codes and types of the binary erosion block.
// Used by the interfaces, the line cells, the control unit and the top level.
`timescale 1ns / 1ps

package bero_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    localparam int CFG_W  = 11;
    localparam int CHAN_W = 8;
    localparam int PIX_W  = 3 * CHAN_W;
    localparam int IDX_W  = 2;
    localparam int NCH_W  = 2;

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int CNT_W = $clog2(MAX_COLS + 2);

    localparam int COLS_CAP = (MAX_COLS < (2 ** CFG_W)) ? MAX_COLS : (2 ** CFG_W) - 1;
    localparam int ROWS_CAP = (MAX_ROWS < (2 ** CFG_W)) ? MAX_ROWS : (2 ** CFG_W) - 1;

    localparam logic [CFG_W-1:0] COLS_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] ROWS_RST  = CFG_W'(480);
    localparam logic [NCH_W-1:0] CHANS_RST = NCH_W'(3);

    typedef enum logic [IDX_W-1:0] {
        REG_COLS  = 2'd0,
        REG_ROWS  = 2'd1,
        REG_CHANS = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_DRAIN = 1'b1
    } opcode_t;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        pix_t pix;
        logic fg;
    } sample_t;

    typedef struct packed {
        logic shift;
        logic emit;
        logic drain;
        logic up_ok;
        logic down_ok;
        logic left_ok;
        logic right_ok;
        logic frame_end;
    } step_t;

endpackage

>>> rtl/bero_if.sv
// Handshake interfaces of the binary erosion block: pixel in, pixel out, configuration.
// Depends on bero_pkg for field widths.
`timescale 1ns / 1ps

interface bero_in_if;
    import bero_pkg::*;

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [CHAN_W-1:0] chan_a;
    logic [CHAN_W-1:0] chan_b;
    logic [CHAN_W-1:0] chan_c;

    modport source (output valid, output opcode, output chan_a, output chan_b,
                    output chan_c, input ready);
    modport sink   (input valid, input opcode, input chan_a, input chan_b,
                    input chan_c, output ready);
endinterface

interface bero_out_if;
    import bero_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_a;
    logic [CHAN_W-1:0] out_b;
    logic [CHAN_W-1:0] out_c;
    logic              frame_end;

    modport source (output valid, output out_a, output out_b, output out_c,
                    output frame_end, input ready);
    modport sink   (input valid, input out_a, input out_b, input out_c,
                    input frame_end, output ready);
endinterface

interface bero_cfg_if;
    import bero_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/bero_cell.sv
// Line cell: one row of delay held in a memory plus a short window of recent samples.
// Cells chain through their delayed output. Depends on bero_pkg.
`timescale 1ns / 1ps

module bero_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         shift,
    input  logic                         restart,
    input  logic [bero_pkg::COL_W-1:0]   cols_m1,
    input  bero_pkg::sample_t            in_smp,
    output logic [2:0]                   tap_fg,
    output bero_pkg::pix_t               tap_pix,
    output bero_pkg::sample_t            dly_smp
);
    import bero_pkg::*;

    sample_t line_mem [MAX_COLS];

    logic [COL_W-1:0] wp_reg;
    logic [COL_W-1:0] wp_next;
    logic [COL_W-1:0] step_addr;
    sample_t          tap1_reg;
    logic             tap2_reg;
    sample_t          rd_reg;

    always_comb
    begin
        step_addr = (wp_reg == cols_m1) ? '0 : wp_reg + 1'b1;
        if (restart)
        begin
            wp_next = '0;
        end
        else if (shift)
        begin
            wp_next = step_addr;
        end
        else
        begin
            wp_next = wp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
        end
    end

    // The read runs one entry ahead, so the sample from one row back is ready at the next request.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            line_mem[wp_reg] <= in_smp;
        end
        rd_reg <= line_mem[wp_next];
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            tap1_reg <= in_smp;
            tap2_reg <= tap1_reg.fg;
        end
    end

    assign tap_fg  = {tap2_reg, tap1_reg.fg, in_smp.fg};
    assign tap_pix = tap1_reg.pix;
    assign dly_smp = rd_reg;

endmodule

>>> rtl/bero_ctrl.sv
// Control unit: configuration registers, frame positions, pending count and request decode.
// Depends on bero_pkg and the configuration interface.
`timescale 1ns / 1ps

module bero_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    bero_cfg_if.sink                     cfg,
    input  logic                         accept,
    input  logic                         opcode,
    output logic [bero_pkg::COL_W-1:0]   cols_m1,
    output logic [bero_pkg::NCH_W-1:0]   chans,
    output logic                         restart,
    output bero_pkg::step_t              step
);
    import bero_pkg::*;

    logic [CFG_W-1:0] cols_reg, cols_next;
    logic [CFG_W-1:0] rows_reg, rows_next;
    logic [NCH_W-1:0] chans_reg, chans_next;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [CNT_W-1:0] pending_reg, pending_next;
    logic             full_reg, full_next;

    logic [CFG_W-1:0] cols_eff;
    logic [CFG_W-1:0] rows_eff;
    logic [ROW_W-1:0] rows_m1;
    logic             pend_full;
    logic             push_ok;
    logic             drain_ok;
    logic             in_col_last, in_row_last;
    logic             out_col_last, out_row_last;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        if (cols_reg < CFG_W'(2))
        begin
            cols_eff = CFG_W'(2);
        end
        else if (cols_reg > CFG_W'(COLS_CAP))
        begin
            cols_eff = CFG_W'(COLS_CAP);
        end
        else
        begin
            cols_eff = cols_reg;
        end

        if (rows_reg < CFG_W'(2))
        begin
            rows_eff = CFG_W'(2);
        end
        else if (rows_reg > CFG_W'(ROWS_CAP))
        begin
            rows_eff = CFG_W'(ROWS_CAP);
        end
        else
        begin
            rows_eff = rows_reg;
        end
    end

    assign cols_m1 = COL_W'(cols_eff - 1'b1);
    assign rows_m1 = ROW_W'(rows_eff - 1'b1);
    assign chans   = (chans_reg == '0) ? NCH_W'(1) : chans_reg;

    assign in_col_last  = (in_col_reg == cols_m1);
    assign in_row_last  = (in_row_reg == rows_m1);
    assign out_col_last = (out_col_reg == cols_m1);
    assign out_row_last = (out_row_reg == rows_m1);
    assign pend_full    = (pending_reg == (CNT_W'(cols_m1) + CNT_W'(2)));

    assign push_ok  = accept && (opcode == OP_PUSH) && !full_reg;
    assign drain_ok = accept && (opcode == OP_DRAIN) && full_reg && (pending_reg != '0);

    always_comb
    begin
        step.shift     = push_ok || drain_ok;
        step.emit      = drain_ok || (push_ok && pend_full);
        step.drain     = drain_ok;
        step.up_ok     = (out_row_reg != '0);
        step.down_ok   = !out_row_last;
        step.left_ok   = (out_col_reg != '0);
        step.right_ok  = !out_col_last;
        step.frame_end = out_row_last && out_col_last;
    end

    always_comb
    begin
        cols_next  = cols_reg;
        rows_next  = rows_reg;
        chans_next = chans_reg;
        restart    = 1'b0;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_COLS:
                begin
                    cols_next = cfg.data;
                    restart   = 1'b1;
                end
                REG_ROWS:
                begin
                    rows_next = cfg.data;
                    restart   = 1'b1;
                end
                REG_CHANS:
                begin
                    chans_next = cfg.data[NCH_W-1:0];
                    restart    = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pending_next = pending_reg;
        full_next    = full_reg;

        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            pending_next = '0;
            full_next    = 1'b0;
        end
        else
        begin
            if (push_ok)
            begin
                if (in_col_last)
                begin
                    in_col_next = '0;
                    if (in_row_last)
                    begin
                        in_row_next = '0;
                        full_next   = 1'b1;
                    end
                    else
                    begin
                        in_row_next = in_row_reg + 1'b1;
                    end
                end
                else
                begin
                    in_col_next = in_col_reg + 1'b1;
                end
                if (!pend_full)
                begin
                    pending_next = pending_reg + 1'b1;
                end
            end

            if (drain_ok)
            begin
                pending_next = pending_reg - 1'b1;
                if (pending_reg == CNT_W'(1))
                begin
                    full_next = 1'b0;
                end
            end

            if (step.emit)
            begin
                if (out_col_last)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_last ? '0 : out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg    <= COLS_RST;
            rows_reg    <= ROWS_RST;
            chans_reg   <= CHANS_RST;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pending_reg <= '0;
            full_reg    <= 1'b0;
        end
        else
        begin
            cols_reg    <= cols_next;
            rows_reg    <= rows_next;
            chans_reg   <= chans_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pending_reg <= pending_next;
            full_reg    <= full_next;
        end
    end

endmodule

>>> rtl/binary_erosion_3x3_top.sv
// Top level of the streaming 3x3 binary erosion block.
// Depends on bero_pkg, the interfaces in bero_if, bero_ctrl and bero_cell.
//
//   Channel   Role   Payload                                  Request taken when
//   cfg       sink   index, data                              valid && ready
//   pix_in    sink   opcode, chan_a, chan_b, chan_c           valid && ready
//   pix_out   source out_a, out_b, out_c, frame_end           valid && ready
//
// One request is taken per clock unless stalled; its result, if any, is shown the next cycle.
// Results trail pushes by image_columns + 1 pixels; drain requests flush the last of them.
// Two chained line cells each hold one row in a memory with one write and one read per cycle.
// pix_in.ready drops only while the output register is full and pix_out.ready is low.
// Reset clears control state only; the line memories need no clearing pass.
`timescale 1ns / 1ps

module binary_erosion_3x3_top (
    input  logic      clk,
    input  logic      rst_n,
    bero_cfg_if.sink  cfg,
    bero_in_if.sink   pix_in,
    bero_out_if.source pix_out
);
    import bero_pkg::*;

    logic             accept;
    logic [COL_W-1:0] cols_m1;
    logic [NCH_W-1:0] chans;
    logic             restart;
    step_t            step;

    sample_t          new_smp;
    logic [2:0]       dn_fg;
    logic [2:0]       mid_fg;
    logic [2:0]       up_fg;
    logic [2:0]       col_ok;
    pix_t             ctr_pix;
    sample_t          row1_smp;
    sample_t          row2_smp;
    logic [1:0]       up_reg;
    logic             keep;

    logic             out_valid_reg, out_valid_next;
    pix_t             out_pix_reg;
    logic             out_end_reg;

    assign pix_in.ready = !out_valid_reg || pix_out.ready;
    assign accept       = pix_in.valid && pix_in.ready;

    bero_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .accept  (accept),
        .opcode  (pix_in.opcode),
        .cols_m1 (cols_m1),
        .chans   (chans),
        .restart (restart),
        .step    (step)
    );

    always_comb
    begin
        if (step.drain)
        begin
            new_smp.pix = '0;
        end
        else
        begin
            new_smp.pix = {pix_in.chan_c & {CHAN_W{chans == NCH_W'(3)}},
                           pix_in.chan_b & {CHAN_W{chans >= NCH_W'(2)}},
                           pix_in.chan_a};
        end
        new_smp.fg = |new_smp.pix;
    end

    bero_cell u_cell0 (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (step.shift),
        .restart (restart),
        .cols_m1 (cols_m1),
        .in_smp  (new_smp),
        .tap_fg  (dn_fg),
        .tap_pix (),
        .dly_smp (row1_smp)
    );

    bero_cell u_cell1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (step.shift),
        .restart (restart),
        .cols_m1 (cols_m1),
        .in_smp  (row1_smp),
        .tap_fg  (mid_fg),
        .tap_pix (ctr_pix),
        .dly_smp (row2_smp)
    );

    always_ff @(posedge clk)
    begin
        if (step.shift)
        begin
            up_reg <= {up_reg[0], row2_smp.fg};
        end
    end

    // Bit 0 of each window row is the right neighbor, bit 2 the left one.
    assign up_fg  = {up_reg, row2_smp.fg};
    assign col_ok = {step.left_ok, 1'b1, step.right_ok};

    always_comb
    begin
        keep = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            keep = keep
                 & (up_fg[i]  | !step.up_ok   | !col_ok[i])
                 & (mid_fg[i] | !col_ok[i])
                 & (dn_fg[i]  | !step.down_ok | !col_ok[i]);
        end
    end

    always_comb
    begin
        if (step.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.emit)
        begin
            out_pix_reg <= keep ? ctr_pix : '0;
            out_end_reg <= step.frame_end;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.out_a     = out_pix_reg[CHAN_W-1:0];
    assign pix_out.out_b     = out_pix_reg[2*CHAN_W-1:CHAN_W];
    assign pix_out.out_c     = out_pix_reg[3*CHAN_W-1:2*CHAN_W];
    assign pix_out.frame_end = out_end_reg;

endmodule

>>> rtl/bero_checker.sv
// Port-level checker of the binary erosion block, bound to the top level.
// Depends on the assertion macros in binary_erosion_3x3_top_macros.svh.
`timescale 1ns / 1ps
`include "binary_erosion_3x3_top_macros.svh"

module bero_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_a,
    input logic [7:0] out_b,
    input logic [7:0] out_c,
    input logic       frame_end
);

    `BERO_ASSERT_IMP(a_out_after_req, $rose(out_valid), $past(in_valid && in_ready), "result appeared without a request")
    `BERO_ASSERT_IMP(a_stall_blocks_in, out_valid && !out_ready, !in_ready, "request taken while a result is stalled")
    `BERO_ASSERT_IMP(a_empty_takes_in, !out_valid, in_ready, "input not ready with an empty output stage")
    `BERO_ASSERT_NXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable({out_a, out_b, out_c, frame_end}), "stalled result changed")

endmodule

bind binary_erosion_3x3_top bero_checker u_bero_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .out_a     (pix_out.out_a),
    .out_b     (pix_out.out_b),
    .out_c     (pix_out.out_c),
    .frame_end (pix_out.frame_end)
);

>>> bench/tb.sv
// Self-checking testbench for binary_erosion_3x3_top: directed frames, then random frames.
// Needs bero_pkg, the handshake interfaces of bero_if and the RTL of the block.
// Each result is matched to a listed value or an in-bench predictor; both sides stall randomly.
`timescale 1ns / 1ps

module tb;
    import bero_pkg::*;

    localparam int DELAY_DEPTH = MAX_COLS + 2;
    localparam int HIST_DEPTH  = 2 * MAX_COLS + 2;
    localparam int SETTLE      = 4;
    localparam int HOLD_AT     = 40;
    localparam int HOLD_LEN    = 300;
    localparam int RAND_ITEMS  = 540;

    typedef struct packed {
        logic [CHAN_W-1:0] a, b, c;
        logic              fe;
    } pixel_res_t;

    typedef struct {
        bit                is_cfg;
        cfg_reg_t          idx;
        logic [CFG_W-1:0]  val;
        opcode_t           op;
        logic [CHAN_W-1:0] a, b, c;
        bit                typed;
        pixel_res_t        want;
    } plan_row_t;

    localparam pixel_res_t NO_RES = '0;

    bit   clk;
    logic rst_n;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bero_in_if  in_ch ();
    bero_out_if out_ch ();
    bero_cfg_if cfg_ch ();

    binary_erosion_3x3_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .pix_in  (in_ch),
        .pix_out (out_ch)
    );

    logic [CFG_W-1:0] cols_reg, rows_reg;
    logic [NCH_W-1:0] chans_reg;
    logic [PIX_W-1:0] line_pix [DELAY_DEPTH];
    bit               line_fg [HIST_DEPTH];
    int               pix_wp, fg_wp, in_r, in_c, out_r, out_c, owed;
    bit               frame_done;

    pixel_res_t eroded_pixels_q [$];
    plan_row_t  plan [$];

    bit calm;
    int errors, results_checked, frames_seen;
    int pushes_taken, drains_taken, ignored_items, reg_writes;

    function automatic int cols_eff();
        if (cols_reg < 2) return 2;
        if (cols_reg > MAX_COLS) return MAX_COLS;
        return cols_reg;
    endfunction

    function automatic int rows_eff();
        if (rows_reg < 2) return 2;
        if (rows_reg > MAX_ROWS) return MAX_ROWS;
        return rows_reg;
    endfunction

    function automatic int chans_eff();
        return (chans_reg == 0) ? 1 : chans_reg;
    endfunction

    function automatic void restart_frame();
        in_r = 0;
        in_c = 0;
        out_r = 0;
        out_c = 0;
        owed = 0;
        frame_done = 1'b0;
    endfunction

    function automatic void apply_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
        case (idx)
            REG_COLS:  cols_reg = val;
            REG_ROWS:  rows_reg = val;
            REG_CHANS: chans_reg = val[NCH_W-1:0];
            default:   return;
        endcase
        restart_frame();
    endfunction

    function automatic void keep_pixel(logic [CHAN_W-1:0] a, b, c);
        logic [PIX_W-1:0] v;
        bit               fg;
        v = '0;
        v[CHAN_W-1:0] = a;
        fg = (a != 0);
        if (chans_eff() >= 2)
        begin
            v[2*CHAN_W-1:CHAN_W] = b;
            fg = fg || (b != 0);
        end
        if (chans_eff() >= 3)
        begin
            v[3*CHAN_W-1:2*CHAN_W] = c;
            fg = fg || (c != 0);
        end
        line_pix[pix_wp] = v;
        line_fg[fg_wp] = fg;
    endfunction

    function automatic void step_ptrs();
        pix_wp = (pix_wp + 1) % DELAY_DEPTH;
        fg_wp = (fg_wp + 1) % HIST_DEPTH;
    endfunction

    // The pixel leaving the window is cols+1 slots behind the write pointers.
    function automatic pixel_res_t erode_next();
        int               cols, rows, r, c, off;
        bit               keep;
        logic [PIX_W-1:0] v;
        pixel_res_t       res;
        cols = cols_eff();
        rows = rows_eff();
        keep = 1'b1;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                r = out_r + dr;
                c = out_c + dc;
                if (r >= 0 && r < rows && c >= 0 && c < cols)
                begin
                    off = fg_wp + 2 * HIST_DEPTH - (cols + 1) + dr * cols + dc;
                    if (!line_fg[off % HIST_DEPTH])
                        keep = 1'b0;
                end
            end
        end
        v = line_pix[(pix_wp + DELAY_DEPTH - (cols + 1)) % DELAY_DEPTH];
        if (!keep)
            v = '0;
        res.a = v[CHAN_W-1:0];
        res.b = v[2*CHAN_W-1:CHAN_W];
        res.c = v[3*CHAN_W-1:2*CHAN_W];
        res.fe = (out_r == rows - 1) && (out_c == cols - 1);
        out_c++;
        if (out_c >= cols)
        begin
            out_c = 0;
            out_r++;
            if (out_r >= rows)
                out_r = 0;
        end
        return res;
    endfunction

    function automatic bit erosion_step(input opcode_t op, input logic [CHAN_W-1:0] a, b, c,
                                        output bit emitted, output pixel_res_t res);
        int cols, rows;
        cols = cols_eff();
        rows = rows_eff();
        emitted = 1'b0;
        res = '0;
        if (op == OP_PUSH)
        begin
            if (frame_done)
                return 1'b0;
            keep_pixel(a, b, c);
            owed++;
            if (owed > cols + 1)
            begin
                res = erode_next();
                owed--;
                emitted = 1'b1;
            end
            step_ptrs();
            in_c++;
            if (in_c >= cols)
            begin
                in_c = 0;
                in_r++;
                if (in_r >= rows)
                begin
                    in_r = 0;
                    frame_done = 1'b1;
                end
            end
            return 1'b1;
        end
        if (!frame_done || owed == 0)
            return 1'b0;
        keep_pixel('0, '0, '0);
        res = erode_next();
        step_ptrs();
        owed--;
        if (owed == 0)
            frame_done = 1'b0;
        emitted = 1'b1;
        return 1'b1;
    endfunction

    function automatic int unsigned stall_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    endfunction

    function automatic int unsigned sender_gap();
        if (calm || $urandom_range(0, 3) != 0)
            return 0;
        return stall_len();
    endfunction

    function automatic plan_row_t reg_row(cfg_reg_t idx, logic [CFG_W-1:0] val);
        plan_row_t row;
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.val = val;
        row.op = OP_PUSH;
        row.a = '0;
        row.b = '0;
        row.c = '0;
        row.typed = 1'b0;
        row.want = NO_RES;
        return row;
    endfunction

    function automatic plan_row_t pix_row(opcode_t op, logic [CHAN_W-1:0] a, b, c);
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.idx = REG_COLS;
        row.val = '0;
        row.op = op;
        row.a = a;
        row.b = b;
        row.c = c;
        row.typed = 1'b0;
        row.want = NO_RES;
        return row;
    endfunction

    function automatic plan_row_t checked_row(opcode_t op, logic [CHAN_W-1:0] a, b, c,
                                              logic [CHAN_W-1:0] wa, wb, wc, logic wfe);
        plan_row_t row;
        row = pix_row(op, a, b, c);
        row.typed = 1'b1;
        row.want = '{a: wa, b: wb, c: wc, fe: wfe};
        return row;
    endfunction

    task automatic send_item(input opcode_t op, input logic [CHAN_W-1:0] a, b, c,
                             input bit typed, input pixel_res_t want);
        int unsigned gap;
        bit          took, emitted;
        pixel_res_t  res;
        gap = sender_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.chan_a <= a;
        in_ch.chan_b <= b;
        in_ch.chan_c <= c;
        do @(posedge clk); while (!in_ch.ready);
        took = erosion_step(op, a, b, c, emitted, res);
        if (emitted)
            eroded_pixels_q.push_back(typed ? want : res);
        if (!took)
            ignored_items++;
        else if (op == OP_PUSH)
            pushes_taken++;
        else
            drains_taken++;
        @(negedge clk);
    endtask

    task automatic quiet_until_drained();
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (eroded_pixels_q.size() != 0);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        quiet_until_drained();
        repeat (SETTLE) @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        apply_reg(idx, val);
        reg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_frame(input int pushes_n, input int drains_n, input int bg_pct,
                             input int pause_at);
        logic [CHAN_W-1:0] a, b, c;
        for (int i = 0; i < pushes_n; i++)
        begin
            if (i == pause_at)
                quiet_until_drained();
            if ($urandom_range(0, 11) == 0)
                send_item(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, NO_RES);
            a = 8'($urandom);
            b = 8'($urandom);
            c = 8'($urandom);
            if ($urandom_range(0, 99) < bg_pct)
            begin
                a = '0;
                if (chans_eff() >= 2)
                    b = '0;
                if (chans_eff() >= 3)
                    c = '0;
            end
            send_item(OP_PUSH, a, b, c, 1'b0, NO_RES);
        end
        for (int i = 0; i < drains_n; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_item(OP_PUSH, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, NO_RES);
            send_item(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, NO_RES);
        end
        if (drains_n == cols_eff() + 1 && $urandom_range(0, 3) == 0)
            send_item(OP_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, NO_RES);
    endtask

    initial
    begin
        int               ext_cols [3];
        int               ext_rows [3];
        int               ext_chans [3];
        int               bg, total, n_frames, kind, base;
        logic [CFG_W-1:0] cv, rv;
        ext_cols = '{12, 1, 0};
        ext_rows = '{0, 9, 1};
        ext_chans = '{3, 0, 2};

        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.opcode <= OP_PUSH;
        in_ch.chan_a <= '0;
        in_ch.chan_b <= '0;
        in_ch.chan_c <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_COLS;
        cfg_ch.data <= '0;
        calm = 1'b0;

        cols_reg = COLS_RST;
        rows_reg = ROWS_RST;
        chans_reg = CHANS_RST;
        pix_wp = 0;
        fg_wp = 0;
        foreach (line_pix[i])
            line_pix[i] = '0;
        foreach (line_fg[i])
            line_fg[i] = 1'b0;
        restart_frame();

        // 2x2 frames. The channel count stays at its reset value for the first one.
        plan.push_back(reg_row(REG_COLS, 11'd2));
        plan.push_back(reg_row(REG_ROWS, 11'd2));
        plan.push_back(pix_row(OP_DRAIN, 8'hFF, 8'hFF, 8'hFF));
        plan.push_back(pix_row(OP_PUSH, 8'hFF, 8'hFF, 8'hFF));
        plan.push_back(pix_row(OP_PUSH, 8'h00, 8'h00, 8'h01));
        plan.push_back(pix_row(OP_PUSH, 8'h80, 8'h00, 8'h00));
        plan.push_back(checked_row(OP_PUSH, 8'h01, 8'h02, 8'h03, 8'hFF, 8'hFF, 8'hFF, 1'b0));
        plan.push_back(pix_row(OP_PUSH, 8'h07, 8'h07, 8'h07));
        plan.push_back(checked_row(OP_DRAIN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 1'b0));
        plan.push_back(checked_row(OP_DRAIN, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 1'b0));
        plan.push_back(checked_row(OP_DRAIN, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 1'b1));
        plan.push_back(reg_row(REG_CHANS, 11'd1));
        plan.push_back(pix_row(OP_PUSH, 8'h05, 8'h09, 8'h09));
        plan.push_back(pix_row(OP_PUSH, 8'h06, 8'hAA, 8'hAA));
        plan.push_back(pix_row(OP_PUSH, 8'h07, 8'h00, 8'h00));
        plan.push_back(checked_row(OP_PUSH, 8'h08, 8'h01, 8'h01, 8'h05, 8'h00, 8'h00, 1'b0));
        plan.push_back(checked_row(OP_DRAIN, 8'h00, 8'h00, 8'h00, 8'h06, 8'h00, 8'h00, 1'b0));
        plan.push_back(checked_row(OP_DRAIN, 8'h00, 8'h00, 8'h00, 8'h07, 8'h00, 8'h00, 1'b0));
        plan.push_back(checked_row(OP_DRAIN, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00, 1'b1));
        plan.push_back(reg_row(REG_CHANS, 11'd2));
        plan.push_back(pix_row(OP_PUSH, 8'h00, 8'h00, 8'hFF));
        plan.push_back(pix_row(OP_PUSH, 8'h11, 8'h22, 8'h33));
        plan.push_back(pix_row(OP_PUSH, 8'h44, 8'h55, 8'h66));
        plan.push_back(checked_row(OP_PUSH, 8'h77, 8'h88, 8'h99, 8'h00, 8'h00, 8'h00, 1'b0));
        plan.push_back(checked_row(OP_DRAIN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        plan.push_back(checked_row(OP_DRAIN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        plan.push_back(checked_row(OP_DRAIN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
        plan.push_back(pix_row(OP_PUSH, 8'h12, 8'h34, 8'h56));
        plan.push_back(reg_row(REG_COLS, 11'd3));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_reg(plan[i].idx, plan[i].val);
            else
                send_item(plan[i].op, plan[i].a, plan[i].b, plan[i].c, plan[i].typed,
                          plan[i].want);
        end

        // Frames with out-of-range sizes; the first one pauses the sender until all is out.
        for (int p = 0; p < 3; p++)
        begin
            write_reg(REG_COLS, CFG_W'(ext_cols[p]));
            write_reg(REG_ROWS, CFG_W'(ext_rows[p]));
            write_reg(REG_CHANS, CFG_W'(ext_chans[p]));
            total = cols_eff() * rows_eff();
            run_frame(total, cols_eff() + 1, (p == 1) ? 0 : 5 * p + 3,
                      (p == 0) ? total * 3 / 4 : -1);
        end

        base = pushes_taken + drains_taken;
        while (pushes_taken + drains_taken - base < RAND_ITEMS)
        begin
            cv = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 40))
                                              : CFG_W'($urandom_range(2, 8));
            rv = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 12))
                                              : CFG_W'($urandom_range(2, 6));
            write_reg(REG_COLS, cv);
            write_reg(REG_ROWS, rv);
            write_reg(REG_CHANS, CFG_W'($urandom_range(0, 3)));
            calm = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 3))
                0:       bg = 0;
                1:       bg = 5;
                2:       bg = 20;
                default: bg = 50;
            endcase
            total = cols_eff() * rows_eff();
            n_frames = ($urandom_range(0, 3) == 0) ? 2 : 1;
            for (int f = 0; f < n_frames; f++)
            begin
                kind = $urandom_range(0, 9);
                if (kind == 0)
                begin
                    run_frame($urandom_range(1, total - 1), 0, bg, -1);
                    break;
                end
                else if (kind == 1)
                begin
                    run_frame(total, $urandom_range(0, cols_eff()), bg, -1);
                    break;
                end
                run_frame(total, cols_eff() + 1, bg,
                          ($urandom_range(0, 5) == 0) ? $urandom_range(1, total - 1) : -1);
            end
        end
        calm = 1'b0;

        quiet_until_drained();
        repeat (20) @(negedge clk);

        $display("Run covered %0d frame ends over %0d register writes, clamped sizes included.",
                 frames_seen, reg_writes);
        $display("%0d pushes and %0d drains taken, %0d requests ignored, %0d pixels checked.",
                 pushes_taken, drains_taken, ignored_items, results_checked);
        if (errors == 0 && eroded_pixels_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int unsigned stall;
        pixel_res_t  got, want;
        stall = 0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall == 0 && !calm && $urandom_range(0, 4) == 0)
                stall = stall_len();
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                stall--;
            end
            else
                out_ch.ready <= 1'b1;
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{a: out_ch.out_a, b: out_ch.out_b, c: out_ch.out_c,
                        fe: out_ch.frame_end};
                if (eroded_pixels_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected pixel, expected none, actual %h %h %h end=%b",
                             $time, got.a, got.b, got.c, got.fe);
                end
                else
                begin
                    want = eroded_pixels_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t: expected %h %h %h end=%b, actual %h %h %h end=%b",
                                 $time, want.a, want.b, want.c, want.fe,
                                 got.a, got.b, got.c, got.fe);
                    end
                end
                if (got.fe === 1'b1)
                    frames_seen++;
                results_checked++;
                // Long hold-off so that the output fills and the input stalls.
                if (results_checked == HOLD_AT)
                    stall = HOLD_LEN;
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
